// ===== design/ctdi_pkg.sv =====
// ----------------------------------------------------------------------------
// ctdi_pkg
// shared types and constants of the convolutional time deinterleaver
// ----------------------------------------------------------------------------
package ctdi_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned CPB_W   = 9;

  localparam logic [CPB_W-1:0] CPB_RESET = 9'd256;

  // register indexes, byte address is four times the index
  localparam logic [1:0] REG_INTERLEAVE_ON = 2'd0;
  localparam logic [1:0] REG_DEPTH         = 2'd1;
  localparam logic [1:0] REG_DELAY_UNIT    = 2'd2;

  // output queue entries, covers the two pipeline stages plus two waiting cells
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic               interleave_on;
    logic [DEPTH_W-1:0] depth;
    logic [CPB_W-1:0]   delay_unit;
    logic               clear;
  } cfg_t;

endpackage

// ===== design/convolutional_time_deinterleaver_top.sv =====
// ----------------------------------------------------------------------------
// convolutional_time_deinterleaver_top
// convolutional de-interleaver: rows of circular delay lines held in one ram
// ----------------------------------------------------------------------------
//  port group        direction  handshake           payload
//  apb config        in/out     psel/penable        paddr, pwdata, prdata
//  input cells       in         in_valid/in_ready   cell_in, last_in_block
//  output cells      out        out_valid/out_ready cell_out
//
//  one cell per cycle sustained while out_ready keeps the queue draining; each
//  cell passes the pointer ram read, the store ram read, then the queue write,
//  and its result is valid and can leave once it is in the queue
//  in_ready drops once queued plus in-flight cells reach four
//  reset and any write to a defined register clear pointers and row counter
//  at once; the store itself is not swept, a per-row wrap flag makes unwritten cells read 0
// ----------------------------------------------------------------------------
module convolutional_time_deinterleaver_top
  import ctdi_pkg::*;
#(
  parameter int unsigned MAX_DEPTH           = 15,
  parameter int unsigned MAX_CELLS_PER_BLOCK = 256,
  parameter int unsigned CELL_WIDTH          = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CELL_WIDTH-1:0] cell_in_i,
  input  logic                         last_in_block_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CELL_WIDTH-1:0] cell_out_o
);

  localparam int unsigned STORE_SIZE =
      MAX_CELLS_PER_BLOCK * MAX_DEPTH * (MAX_DEPTH + 1) / 2;
  localparam int unsigned ADDR_W    = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int unsigned LEN_W     = $clog2(STORE_SIZE + 1);
  localparam int unsigned DEPTH_MAX = (1 << DEPTH_W) - 1;
  localparam int unsigned DEPTH_CAP = (MAX_DEPTH < DEPTH_MAX) ? MAX_DEPTH : DEPTH_MAX;
  localparam int unsigned ROWS      = DEPTH_CAP + 1;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned FCNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PTR_WIDTH = ADDR_W + 1;

  cfg_t             cfg;
  logic             in_fire;
  logic             seq_active;
  logic [ROW_W-1:0] seq_row;
  logic [LEN_W-1:0] seq_base;
  logic [LEN_W-1:0] seq_len;
  logic [FCNT_W-1:0] fifo_count;
  logic [FCNT_W:0]   busy;

  // stage 1: pointer ram data available
  logic                  s1_valid_q;
  logic [CELL_WIDTH-1:0] s1_cell_q;
  logic [ROW_W-1:0]      s1_row_q;
  logic [LEN_W-1:0]      s1_base_q;
  logic [LEN_W-1:0]      s1_len_q;
  logic                  s1_use_q;

  // stage 2: store ram data available
  logic                  s2_valid_q;
  logic [CELL_WIDTH-1:0] s2_cell_q;
  logic                  s2_use_q;
  logic                  s2_zero_q;

  logic                  fwd_hit_q;
  logic [PTR_WIDTH-1:0]  fwd_data_q;
  logic [ROWS-1:0]       ptr_vld_q;

  logic [PTR_WIDTH-1:0]  ptr_rdata;
  logic [PTR_WIDTH-1:0]  ptr_cur;
  logic [PTR_WIDTH-1:0]  ptr_wdata;
  logic [ADDR_W-1:0]     pos;
  logic                  wrapped;
  logic                  pos_last;
  logic                  s1_wr;
  logic [ADDR_W-1:0]     store_addr;
  logic [CELL_WIDTH-1:0] store_rdata;
  logic [CELL_WIDTH-1:0] s2_result;
  logic [CELL_WIDTH-1:0] fifo_data;

  ctdi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctdi_row_seq #(
    .MAX_DEPTH           (MAX_DEPTH),
    .MAX_CELLS_PER_BLOCK (MAX_CELLS_PER_BLOCK),
    .ROW_W               (ROW_W),
    .LEN_W               (LEN_W)
  ) u_row_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (in_fire),
    .last_i    (last_in_block_i),
    .active_o  (seq_active),
    .row_o     (seq_row),
    .base_o    (seq_base),
    .len_o     (seq_len)
  );

  // room for everything in flight plus the queue
  assign busy = (FCNT_W+1)'(fifo_count) + (FCNT_W+1)'(s1_valid_q) +
                (FCNT_W+1)'(s2_valid_q);
  assign in_ready_o = busy < (FCNT_W+1)'(FIFO_DEPTH);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
      // pointer written this cycle for the row being read: ram returns stale data
      fwd_hit_q  <= in_fire && s1_wr && (s1_row_q == seq_row) && !cfg.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cell_q <= cell_in_i;
      s1_row_q  <= seq_row;
      s1_base_q <= seq_base;
      s1_len_q  <= seq_len;
      s1_use_q  <= seq_active && (seq_len != '0);
    end
    fwd_data_q <= ptr_wdata;
    s2_cell_q  <= s1_cell_q;
    s2_use_q   <= s1_use_q;
    s2_zero_q  <= !wrapped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_vld_q <= '0;
    end else if (cfg.clear) begin
      ptr_vld_q <= '0;
    end else if (s1_wr) begin
      ptr_vld_q[s1_row_q] <= 1'b1;
    end
  end

  ctdi_ram #(
    .WIDTH (PTR_WIDTH),
    .DEPTH (ROWS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_row_q),
    .wdata_i (ptr_wdata),
    .raddr_i (seq_row),
    .rdata_o (ptr_rdata)
  );

  always_comb begin
    if (fwd_hit_q) begin
      ptr_cur = fwd_data_q;
    end else if (ptr_vld_q[s1_row_q]) begin
      ptr_cur = ptr_rdata;
    end else begin
      ptr_cur = '0;
    end
  end

  assign pos        = ptr_cur[ADDR_W-1:0];
  assign wrapped    = ptr_cur[ADDR_W];
  assign pos_last   = (LEN_W'(pos) + LEN_W'(1)) == s1_len_q;
  assign ptr_wdata  = pos_last ? {1'b1, {ADDR_W{1'b0}}} :
                                 {wrapped, ADDR_W'(pos + 1'b1)};
  assign s1_wr      = s1_valid_q && s1_use_q;
  assign store_addr = ADDR_W'(s1_base_q + LEN_W'(pos));

  // oldest cell of the row is read and replaced in the same cycle
  ctdi_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (STORE_SIZE)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (store_addr),
    .wdata_i (s1_cell_q),
    .raddr_i (store_addr),
    .rdata_o (store_rdata)
  );

  always_comb begin
    if (!s2_use_q) begin
      s2_result = s2_cell_q;
    end else if (s2_zero_q) begin
      s2_result = '0;
    end else begin
      s2_result = store_rdata;
    end
  end

  ctdi_out_fifo #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .data_i  (s2_result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (fifo_data),
    .count_o (fifo_count)
  );

  assign cell_out_o = fifo_data;

endmodule

// ===== design/ctdi_ram.sv =====
// ----------------------------------------------------------------------------
// ctdi_ram
// generic single write port ram, one read port with registered data
// ----------------------------------------------------------------------------
module ctdi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ctdi_cfg.sv =====
// ----------------------------------------------------------------------------
// ctdi_cfg
// apb register file: interleave enable, depth and delay unit
// ----------------------------------------------------------------------------
module ctdi_cfg
  import ctdi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic               on_q, on_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [CPB_W-1:0]   cpb_q, cpb_d;
  logic               wr_en;
  logic               wr_hit;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    on_d    = on_q;
    depth_d = depth_q;
    cpb_d   = cpb_q;
    wr_hit  = 1'b0;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_INTERLEAVE_ON: begin
          on_d   = pwdata[0];
          wr_hit = 1'b1;
        end
        REG_DEPTH: begin
          depth_d = pwdata[DEPTH_W-1:0];
          wr_hit  = 1'b1;
        end
        REG_DELAY_UNIT: begin
          cpb_d  = pwdata[CPB_W-1:0];
          wr_hit = 1'b1;
        end
        default: begin
          wr_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= 1'b0;
      depth_q <= '0;
      cpb_q   <= CPB_RESET;
    end else begin
      on_q    <= on_d;
      depth_q <= depth_d;
      cpb_q   <= cpb_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INTERLEAVE_ON: prdata = PDATA_W'(on_q);
      REG_DEPTH:         prdata = PDATA_W'(depth_q);
      REG_DELAY_UNIT:    prdata = PDATA_W'(cpb_q);
      default:           prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // clear acts at the same edge that writes the register
  assign cfg_o.interleave_on = on_q;
  assign cfg_o.depth         = depth_q;
  assign cfg_o.delay_unit    = cpb_q;
  assign cfg_o.clear         = wr_hit;

endmodule

// ===== design/ctdi_row_seq.sv =====
// ----------------------------------------------------------------------------
// ctdi_row_seq
// row counter with running base address and row length of the delay store
// ----------------------------------------------------------------------------
module ctdi_row_seq
  import ctdi_pkg::*;
#(
  parameter int unsigned MAX_DEPTH           = 15,
  parameter int unsigned MAX_CELLS_PER_BLOCK = 256,
  parameter int unsigned ROW_W               = 4,
  parameter int unsigned LEN_W               = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             advance_i,
  input  logic             last_i,
  output logic             active_o,
  output logic [ROW_W-1:0] row_o,
  output logic [LEN_W-1:0] base_o,
  output logic [LEN_W-1:0] len_o
);

  logic [DEPTH_W-1:0]       d_sat;
  logic [CPB_W-1:0]         cpb_sat;
  logic [DEPTH_W+CPB_W-1:0] len0_full;
  logic [LEN_W-1:0]         len0;
  logic [LEN_W-1:0]         len;
  logic                     row_wrap;

  logic [ROW_W-1:0] row_q, row_d;
  logic [LEN_W-1:0] base_q, base_d;
  logic [LEN_W-1:0] sub_q, sub_d;

  assign d_sat   = (32'(cfg_i.depth) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : cfg_i.depth;
  assign cpb_sat = (32'(cfg_i.delay_unit) > MAX_CELLS_PER_BLOCK) ?
                   CPB_W'(MAX_CELLS_PER_BLOCK) : cfg_i.delay_unit;

  // row r is (depth - r) units long, sub tracks r units
  assign len0_full = d_sat * cpb_sat;
  assign len0      = LEN_W'(len0_full);
  assign len       = len0 - sub_q;
  assign active_o  = cfg_i.interleave_on && (d_sat != '0);
  assign row_wrap  = last_i || (32'(row_q) == 32'(d_sat));

  always_comb begin
    row_d  = row_q;
    base_d = base_q;
    sub_d  = sub_q;
    if (cfg_i.clear || (advance_i && (!active_o || row_wrap))) begin
      row_d  = '0;
      base_d = '0;
      sub_d  = '0;
    end else if (advance_i) begin
      row_d  = ROW_W'(row_q + 1'b1);
      base_d = base_q + len;
      sub_d  = sub_q + LEN_W'(cpb_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      base_q <= '0;
      sub_q  <= '0;
    end else begin
      row_q  <= row_d;
      base_q <= base_d;
      sub_q  <= sub_d;
    end
  end

  assign row_o  = row_q;
  assign base_o = base_q;
  assign len_o  = len;

endmodule

// ===== design/ctdi_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ctdi_out_fifo
// small output queue that decouples the pipeline from the result consumer
// ----------------------------------------------------------------------------
module ctdi_out_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_q + 1'b1);
    end
    case ({push_i, pop})
      2'b10:   count_d = CW'(count_q + 1'b1);
      2'b01:   count_d = CW'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== design/ctdi_checker.sv =====
// ----------------------------------------------------------------------------
// ctdi_checker
// port level checks of the convolutional time deinterleaver
// ----------------------------------------------------------------------------
module ctdi_checker
  import ctdi_pkg::*;
#(
  parameter int unsigned CELL_WIDTH = 8
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [PADDR_W-1:0]           paddr,
  input logic [PDATA_W-1:0]           pwdata,
  input logic [PDATA_W-1:0]           prdata,
  input logic                         pready,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [CELL_WIDTH-1:0] cell_out_o
);

  logic               in_fire;
  logic               out_fire;
  logic [3:0]         pending_q, pending_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q + 4'(in_fire) - 4'(out_fire);
    depth_d   = depth_q;
    if (psel && penable && pwrite && pready && (paddr[3:2] == REG_DEPTH)) begin
      depth_d = pwdata[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      depth_q   <= '0;
    end else begin
      pending_q <= pending_d;
      depth_q   <= depth_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_out_o))
    else $error("output transaction dropped or changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ##2 out_valid_o)
    else $error("accepted cell did not reach the output in time");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'(FIFO_DEPTH))
    else $error("more cells in flight than the output queue holds");

  a_depth_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[3:2] == REG_DEPTH) |-> prdata == PDATA_W'(depth_q))
    else $error("depth register read back wrong value");

endmodule

bind convolutional_time_deinterleaver_top ctdi_checker #(
  .CELL_WIDTH (CELL_WIDTH)
) u_ctdi_checker (.*);
